// ===== sv/ldt_pkg.sv =====
// ----------------------------------------------------------------------------
// ldt_pkg
// Shared sizes, codes and types of the last-access dependency table.
// ----------------------------------------------------------------------------
package ldt_pkg;

  localparam int NUM_REGS    = 64;
  localparam int MEM_ENTRIES = 32;
  localparam int KEY_W       = 48;
  localparam int ID_W        = 32;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int SLOT_W      = $clog2(MEM_ENTRIES);
  localparam int OWN_DEPTH   = 2 * NUM_REGS + 2 * MEM_ENTRIES;
  localparam int OWN_AW      = $clog2(OWN_DEPTH);

  // owner store layout: reg write, reg read, mem read, mem write
  localparam logic [OWN_AW-1:0] BASE_RW = OWN_AW'(0);
  localparam logic [OWN_AW-1:0] BASE_RR = OWN_AW'(NUM_REGS);
  localparam logic [OWN_AW-1:0] BASE_MR = OWN_AW'(2 * NUM_REGS);
  localparam logic [OWN_AW-1:0] BASE_MW = OWN_AW'(2 * NUM_REGS + MEM_ENTRIES);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;
  localparam logic [1:0] OP_LKP = 2'd2;
  localparam logic [1:0] OP_CLR = 2'd3;

  localparam logic [1:0] SEL_RW = 2'd0;
  localparam logic [1:0] SEL_RR = 2'd1;
  localparam logic [1:0] SEL_MR = 2'd2;
  localparam logic [1:0] SEL_MW = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic              clr_all;
    logic              set;
    logic              clr;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  addr;
  } cam_upd_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              free;
    logic [SLOT_W-1:0] free_slot;
  } cam_res_t;

endpackage

// ===== sv/last_access_dependency_table_top.sv =====
// ----------------------------------------------------------------------------
// last_access_dependency_table_top
// Last-writer / last-reader tables for registers and memory addresses.
// ----------------------------------------------------------------------------
// Usage:
//   One transaction on the in_ stream carries an operation (add, delete if
//   owner matches, lookup, clear) on one of four tables; each produces
//   exactly one result transaction on the out_ stream with hit, owner and
//   status.
//   out_tvalid is registered and rises after the execute state. An item
//   passes through an accept and an execute state: the owner store is a
//   single-port synchronous RAM that is read in the accept cycle and written
//   back in the following execute cycle, so one item is in flight at a time.
//   Register tables keep valid bits in flops; memory tables match the
//   address against a 32-entry tag array combinationally in the accept cycle.
//   Reset clears all valid bits at once; no clearing pass is needed, and a
//   clear operation does the same in its execute cycle.
//   When the receiver stalls, the result is held in the output register and
//   no new item is accepted until it is taken (a new item may be accepted
//   in the same cycle the held result leaves).
// ----------------------------------------------------------------------------
module last_access_dependency_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // key[47:0], instr_id[79:48]
  input  logic [3:0]  in_tuser,   // opcode[1:0], table_select[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // found[0], owner_id[32:1], status[34:33], zero
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic in_acc;

  logic [1:0]                       op_in, sel_in;
  logic [ldt_pkg::KEY_W-1:0]        key_in;
  logic [ldt_pkg::ID_W-1:0]         id_in;
  logic [ldt_pkg::REG_IDX_W-1:0]    ridx_in;

  logic [1:0]                       op_r, sel_r;
  logic [ldt_pkg::KEY_W-1:0]        key_r;
  logic [ldt_pkg::ID_W-1:0]         id_r;
  logic [ldt_pkg::REG_IDX_W-1:0]    ridx_r;
  logic [ldt_pkg::SLOT_W-1:0]       slot_r, slot_nxt;
  logic [ldt_pkg::OWN_AW-1:0]       idx_r, idx_nxt;
  logic                             hit_r, hit_nxt;
  logic                             full_r, full_nxt;
  logic                             rerr_r, rerr_nxt;
  logic [ldt_pkg::ID_W-1:0]         rdata_r;

  logic [ldt_pkg::ID_W-1:0]         own_mem [ldt_pkg::OWN_DEPTH];
  logic [ldt_pkg::NUM_REGS-1:0]     reg_valid_r [2];

  ldt_pkg::cam_upd_t                upd_mr, upd_mw;
  ldt_pkg::cam_res_t                res_mr, res_mw, res_sel;

  logic                             out_valid_r;
  logic [39:0]                      out_data_r, out_data_nxt;
  logic                             ex_ok, del_match, ram_we;
  logic [1:0]                       status;

  assign op_in   = in_tuser[1:0];
  assign sel_in  = in_tuser[3:2];
  assign key_in  = in_tdata[47:0];
  assign id_in   = in_tdata[79:48];
  assign ridx_in = key_in[ldt_pkg::REG_IDX_W-1:0];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  ldt_cam u_cam_mr (.clk(clk), .rst_n(rst_n), .key(key_in), .upd(upd_mr), .res(res_mr));
  ldt_cam u_cam_mw (.clk(clk), .rst_n(rst_n), .key(key_in), .upd(upd_mw), .res(res_mw));

  assign res_sel = (sel_in == ldt_pkg::SEL_MW) ? res_mw : res_mr;

  // accept-cycle decode
  always_comb begin
    rerr_nxt = 1'b0;
    hit_nxt  = 1'b0;
    full_nxt = 1'b0;
    slot_nxt = res_sel.hit ? res_sel.hit_slot : res_sel.free_slot;
    idx_nxt  = ldt_pkg::BASE_RW;
    case (sel_in)
      ldt_pkg::SEL_RW, ldt_pkg::SEL_RR: begin
        rerr_nxt = (op_in != ldt_pkg::OP_CLR) &&
                   (key_in[ldt_pkg::KEY_W-1:ldt_pkg::REG_IDX_W] != '0);
        hit_nxt  = !rerr_nxt && reg_valid_r[sel_in[0]][ridx_in];
        idx_nxt  = (sel_in[0] ? ldt_pkg::BASE_RR : ldt_pkg::BASE_RW)
                   + ldt_pkg::OWN_AW'(ridx_in);
      end
      ldt_pkg::SEL_MR, ldt_pkg::SEL_MW: begin
        hit_nxt  = res_sel.hit;
        full_nxt = (op_in == ldt_pkg::OP_ADD) && !res_sel.hit && !res_sel.free;
        idx_nxt  = (sel_in[0] ? ldt_pkg::BASE_MW : ldt_pkg::BASE_MR)
                   + ldt_pkg::OWN_AW'(slot_nxt);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= op_in;
      sel_r  <= sel_in;
      key_r  <= key_in;
      id_r   <= id_in;
      ridx_r <= ridx_in;
      slot_r <= slot_nxt;
      idx_r  <= idx_nxt;
      hit_r  <= hit_nxt;
      full_r <= full_nxt;
      rerr_r <= rerr_nxt;
    end
  end

  // execute cycle
  assign ex_ok     = (state_r == ST_EXEC) && !rerr_r && !full_r;
  assign del_match = hit_r && (rdata_r == id_r);
  assign ram_we    = ex_ok && (op_r == ldt_pkg::OP_ADD);
  assign status    = rerr_r ? ldt_pkg::ST_RANGE :
                     (full_r ? ldt_pkg::ST_FULL : ldt_pkg::ST_OK);

  // owner store: read at accept, written back at execute, never same cycle
  always_ff @(posedge clk) begin
    if (ram_we) begin
      own_mem[idx_r] <= id_r;
    end
    if (in_acc) begin
      rdata_r <= own_mem[idx_nxt];
    end
  end

  always_comb begin
    upd_mr      = '0;
    upd_mr.slot = slot_r;
    upd_mr.addr = key_r;
    upd_mr.clr_all = ex_ok && (op_r == ldt_pkg::OP_CLR);
    upd_mr.set = ram_we && (sel_r == ldt_pkg::SEL_MR);
    upd_mr.clr = ex_ok && (op_r == ldt_pkg::OP_DEL) && del_match &&
                 (sel_r == ldt_pkg::SEL_MR);
    upd_mw      = upd_mr;
    upd_mw.set  = ram_we && (sel_r == ldt_pkg::SEL_MW);
    upd_mw.clr  = ex_ok && (op_r == ldt_pkg::OP_DEL) && del_match &&
                  (sel_r == ldt_pkg::SEL_MW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_valid_r[0] <= '0;
      reg_valid_r[1] <= '0;
    end else if (ex_ok) begin
      case (op_r)
        ldt_pkg::OP_CLR: begin
          reg_valid_r[0] <= '0;
          reg_valid_r[1] <= '0;
        end
        ldt_pkg::OP_ADD: begin
          if (!sel_r[1]) reg_valid_r[sel_r[0]][ridx_r] <= 1'b1;
        end
        ldt_pkg::OP_DEL: begin
          if (!sel_r[1] && del_match) reg_valid_r[sel_r[0]][ridx_r] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EXEC) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (op_r == ldt_pkg::OP_LKP && hit_r) begin
      out_data_nxt[0]    = 1'b1;
      out_data_nxt[32:1] = rdata_r;
    end
    out_data_nxt[34:33] = status;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_EXEC) && !in_tready)
    else $error("item accepted while another is in flight");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> out_tvalid)
    else $error("execute cycle did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> (!out_valid_r || $past(out_tready)))
    else $error("pending result overwritten");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[34:33] == ldt_pkg::ST_OK))
    else $error("hit reported with error status");

endmodule

// ===== sv/ldt_cam.sv =====
// ----------------------------------------------------------------------------
// ldt_cam
// Fully associative address tag array for one memory table: valid bits and
// addresses, lowest matching entry and lowest free entry.
// ----------------------------------------------------------------------------
module ldt_cam (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ldt_pkg::KEY_W-1:0] key,
  input  ldt_pkg::cam_upd_t         upd,
  output ldt_pkg::cam_res_t         res
);

  logic [ldt_pkg::MEM_ENTRIES-1:0] valid_r;
  logic [ldt_pkg::KEY_W-1:0]       addr_r [ldt_pkg::MEM_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (upd.clr_all) begin
      valid_r <= '0;
    end else if (upd.set) begin
      valid_r[upd.slot] <= 1'b1;
    end else if (upd.clr) begin
      valid_r[upd.slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.set) begin
      addr_r[upd.slot] <= upd.addr;
    end
  end

  // priority pick: scan high to low so the lowest entry wins
  always_comb begin
    res = '0;
    for (int i = ldt_pkg::MEM_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && addr_r[i] == key) begin
        res.hit      = 1'b1;
        res.hit_slot = ldt_pkg::SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        res.free      = 1'b1;
        res.free_slot = ldt_pkg::SLOT_W'(i);
      end
    end
  end

endmodule
